[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that must also hold through reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/smtrb_pkg.sv]
`default_nettype none

package smtrb_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int PTR_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);

   typedef enum logic [2:0] {
      ACT_WRITE_TX  = 3'd0,
      ACT_TX_START  = 3'd1,
      ACT_READ_RX   = 3'd2,
      ACT_PEEK_RX   = 3'd3,
      ACT_XFER_DONE = 3'd4,
      ACT_FAULT     = 3'd5,
      ACT_CLEAR     = 3'd6,
      ACT_NOP       = 3'd7
   } action_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic [7:0] rx_byte;
      logic       fault;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       load_valid;
      logic [7:0] load_byte;
      logic       transfer_active;
      logic       chip_deselect;
      logic       rx_available;
      logic       tx_pending;
      logic [6:0] tx_free;
   } rsp_type;

   // What the memory cycle must still do for the item in flight
   typedef struct packed {
      logic rd;
      logic ld;
      logic desel;
   } pend_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_MEM  = 2'b10
   } state_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(BUFFER_DEPTH - 1)) r = '0;
      else r = p + PTR_W'(1);
      return r;
   endfunction

endpackage

`default_nettype wire

[src/spi_master_tx_rx_ring_buffers.sv]
// Buffer controller for an SPI master: a transmit ring and a receive ring.
// Input channel req_*: one action per item (queue TX byte, start burst,
// read or peek RX byte, transfer done, fault, clear). Result channel rsp_*:
// exactly one result per item, carrying any read or load byte plus status
// and transmit free space after the action.
// The accepting cycle updates pointers and issues the ring reads; in ST_MEM
// the registered memory data is taken into the output register.
// No new item is taken until the current one has passed ST_MEM, since each
// item waits out the registered read of the ring memories.
// While the result waits under rsp_stall no new item is accepted; the
// output register holds its value until taken.
// Reset clears pointers, fill counts, the burst flag and any pending result.
// Ring contents are not cleared; an unwritten entry never reaches a result.
`default_nettype none

module spi_master_tx_rx_ring_buffers (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire smtrb_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output smtrb_pkg::rsp_type     rsp_data
);

   localparam int PW = smtrb_pkg::PTR_W;
   localparam int FW = smtrb_pkg::FILL_W;
   localparam logic [FW-1:0] DEPTH_F = FW'(smtrb_pkg::BUFFER_DEPTH);

   logic [7:0] tx_mem [smtrb_pkg::BUFFER_DEPTH];
   logic [7:0] rx_mem [smtrb_pkg::BUFFER_DEPTH];

   smtrb_pkg::state_type state_ff, state_in;
   logic [PW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [PW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [FW-1:0] tx_fill_ff, tx_fill_in, rx_fill_ff, rx_fill_in;
   logic          active_ff, active_in;
   smtrb_pkg::pend_type pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   smtrb_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [7:0]    tx_rd_ff, rx_rd_ff;
   logic          tx_we, rx_we;
   logic [7:0]    rx_wdata;
   logic          accept;
   logic [FW-1:0] tx_room;
   smtrb_pkg::action_type act;

   assign req_stall = !((state_ff == smtrb_pkg::ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign act       = smtrb_pkg::action_type'(req_data.action);
   assign rx_wdata  = req_data.rx_byte;
   assign tx_room   = DEPTH_F - tx_fill_ff;

   always_comb begin
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      tx_fill_in = tx_fill_ff;
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      rx_fill_in = rx_fill_ff;
      active_in  = active_ff;
      pend_in    = pend_ff;
      tx_we      = 1'b0;
      rx_we      = 1'b0;
      state_in   = state_ff;
      if (accept) begin
         pend_in  = '0;
         state_in = smtrb_pkg::ST_MEM;
         case (act)
            smtrb_pkg::ACT_WRITE_TX: begin
               tx_we      = 1'b1;
               tx_head_in = smtrb_pkg::ring_next(tx_head_ff);
               if (tx_fill_ff < DEPTH_F) tx_fill_in = tx_fill_ff + FW'(1);
            end
            smtrb_pkg::ACT_TX_START: begin
               if (tx_fill_ff != '0) begin
                  pend_in.ld = 1'b1;
                  tx_tail_in = smtrb_pkg::ring_next(tx_tail_ff);
                  tx_fill_in = tx_fill_ff - FW'(1);
                  active_in  = 1'b1;
               end
            end
            smtrb_pkg::ACT_READ_RX: begin
               if (rx_fill_ff != '0) begin
                  pend_in.rd = 1'b1;
                  rx_tail_in = smtrb_pkg::ring_next(rx_tail_ff);
                  rx_fill_in = rx_fill_ff - FW'(1);
               end
            end
            smtrb_pkg::ACT_PEEK_RX: begin
               pend_in.rd = (rx_fill_ff != '0);
            end
            smtrb_pkg::ACT_XFER_DONE: begin
               rx_we      = 1'b1;
               rx_head_in = smtrb_pkg::ring_next(rx_head_ff);
               if (rx_fill_ff < DEPTH_F) rx_fill_in = rx_fill_ff + FW'(1);
               if (tx_fill_ff != '0) begin
                  pend_in.ld = 1'b1;
                  tx_tail_in = smtrb_pkg::ring_next(tx_tail_ff);
                  tx_fill_in = tx_fill_ff - FW'(1);
               end else begin
                  active_in     = 1'b0;
                  pend_in.desel = 1'b1;
               end
            end
            smtrb_pkg::ACT_FAULT: begin
               if (req_data.fault) begin
                  rx_we      = 1'b1;
                  rx_head_in = smtrb_pkg::ring_next(rx_head_ff);
                  if (rx_fill_ff < DEPTH_F) rx_fill_in = rx_fill_ff + FW'(1);
               end
            end
            smtrb_pkg::ACT_CLEAR: begin
               tx_head_in = '0;
               tx_tail_in = '0;
               tx_fill_in = '0;
               rx_head_in = '0;
               rx_tail_in = '0;
               rx_fill_in = '0;
            end
            default: begin
            end
         endcase
      end else if (state_ff == smtrb_pkg::ST_MEM) begin
         state_in = smtrb_pkg::ST_IDLE;
      end
   end

   // Result: pointers and flags already reflect the item; ring data arrives now
   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == smtrb_pkg::ST_MEM) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.read_data       = pend_ff.rd ? rx_rd_ff : 8'd0;
         rsp_data_in.load_valid      = pend_ff.ld;
         rsp_data_in.load_byte       = pend_ff.ld ? tx_rd_ff : 8'd0;
         rsp_data_in.transfer_active = active_ff;
         rsp_data_in.chip_deselect   = pend_ff.desel;
         rsp_data_in.rx_available    = (rx_fill_ff != '0);
         rsp_data_in.tx_pending      = (tx_fill_ff != '0);
         rsp_data_in.tx_free         = 7'(tx_room);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smtrb_pkg::ST_IDLE;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_fill_ff   <= '0;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         rx_fill_ff   <= '0;
         active_ff    <= 1'b0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         tx_fill_ff   <= tx_fill_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         rx_fill_ff   <= rx_fill_in;
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Transmit ring: write at head, read at tail
   always_ff @(posedge clock) begin
      if (tx_we) tx_mem[tx_head_ff] <= req_data.tx_byte;
      if (accept) tx_rd_ff <= tx_mem[tx_tail_ff];
   end

   // Receive ring: write at head, read at tail
   always_ff @(posedge clock) begin
      if (rx_we) rx_mem[rx_head_ff] <= rx_wdata;
      if (accept) rx_rd_ff <= rx_mem[rx_tail_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[src/smtrb_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module smtrb_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire smtrb_pkg::rsp_type rsp_data
);

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   // a stalled result holds
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // no load byte without a load
   `ASSERT_CLK_RST(a_load_zero, clock, reset, rsp_valid && !rsp_data.load_valid |-> rsp_data.load_byte == 8'd0, "load byte without load")

   // burst end releases the chip with nothing loaded
   `ASSERT_CLK_RST(a_deselect, clock, reset, rsp_valid && rsp_data.chip_deselect |-> !rsp_data.transfer_active && !rsp_data.load_valid, "deselect while active")

   // an accepted item gets its result once its ST_MEM cycle is done
   `ASSERT_CLK_RST(a_latency, clock, reset, req_acc |=> ##1 rsp_valid, "result missing after item")

   // no result straight after reset
   `ASSERT_CLK(a_reset, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind spi_master_tx_rx_ring_buffers smtrb_checker u_smtrb_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import smtrb_pkg::*;

   localparam int ITEM_TARGET    = 2000;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_CAP      = 40;

   // Tracks both rings and the burst flag, and queues the status each item should return.
   class ring_tracker;
      logic [7:0]        tx_ring [BUFFER_DEPTH];
      logic [7:0]        rx_ring [BUFFER_DEPTH];
      logic [PTR_W-1:0]  tx_head, tx_tail, rx_head, rx_tail;
      logic [FILL_W-1:0] tx_fill, rx_fill;
      logic              burst_on;
      rsp_type           due_status_q[$];
      int unsigned       errors;

      function new();
         tx_head  = '0;
         tx_tail  = '0;
         rx_head  = '0;
         rx_tail  = '0;
         tx_fill  = '0;
         rx_fill  = '0;
         burst_on = 1'b0;
         errors   = 0;
      endfunction

      function logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
         return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
      endfunction

      // A full ring keeps its count and lets the head run over the oldest entry.
      function void store_rx(input logic [7:0] b);
         rx_ring[rx_head] = b;
         rx_head = advance(rx_head);
         if (rx_fill != FILL_W'(BUFFER_DEPTH)) rx_fill = rx_fill + 1'b1;
      endfunction

      function logic [7:0] take_tx();
         logic [7:0] b;
         b = tx_ring[tx_tail];
         tx_tail = advance(tx_tail);
         tx_fill = tx_fill - 1'b1;
         return b;
      endfunction

      function void note_request(input req_type r);
         rsp_type e;
         e = '0;
         case (action_type'(r.action))
            ACT_WRITE_TX: begin
               tx_ring[tx_head] = r.tx_byte;
               tx_head = advance(tx_head);
               if (tx_fill != FILL_W'(BUFFER_DEPTH)) tx_fill = tx_fill + 1'b1;
            end
            ACT_TX_START: begin
               if (tx_fill != 0) begin
                  e.load_byte  = take_tx();
                  e.load_valid = 1'b1;
                  burst_on     = 1'b1;
               end
            end
            ACT_READ_RX: begin
               if (rx_fill != 0) begin
                  e.read_data = rx_ring[rx_tail];
                  rx_tail = advance(rx_tail);
                  rx_fill = rx_fill - 1'b1;
               end
            end
            ACT_PEEK_RX: begin
               if (rx_fill != 0) e.read_data = rx_ring[rx_tail];
            end
            ACT_XFER_DONE: begin
               store_rx(r.rx_byte);
               if (tx_fill != 0) begin
                  e.load_byte  = take_tx();
                  e.load_valid = 1'b1;
               end else begin
                  burst_on        = 1'b0;
                  e.chip_deselect = 1'b1;
               end
            end
            ACT_FAULT: begin
               if (r.fault) store_rx(r.rx_byte);
            end
            ACT_CLEAR: begin
               // empty both rings, keep the burst flag
               tx_head = '0;
               tx_tail = '0;
               tx_fill = '0;
               rx_head = '0;
               rx_tail = '0;
               rx_fill = '0;
            end
            default: begin
            end
         endcase
         e.transfer_active = burst_on;
         e.rx_available    = (rx_fill != 0);
         e.tx_pending      = (tx_fill != 0);
         e.tx_free         = 7'(BUFFER_DEPTH - int'(tx_fill));
         due_status_q.push_back(e);
      endfunction

      task report_mismatch(input string what);
         if (errors < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_field(input string name, input int got, input int want);
         if (got != want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      endtask

      task check_result(input rsp_type got);
         rsp_type want;
         if (due_status_q.size() == 0) begin
            report_mismatch("result with nothing outstanding");
         end else begin
            want = due_status_q.pop_front();
            check_field("read_data", got.read_data, want.read_data);
            check_field("load_valid", got.load_valid, want.load_valid);
            check_field("load_byte", got.load_byte, want.load_byte);
            check_field("transfer_active", got.transfer_active, want.transfer_active);
            check_field("chip_deselect", got.chip_deselect, want.chip_deselect);
            check_field("rx_available", got.rx_available, want.rx_available);
            check_field("tx_pending", got.tx_pending, want.tx_pending);
            check_field("tx_free", got.tx_free, want.tx_free);
         end
      endtask

      function int pending();
         return due_status_q.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   ring_tracker book = new();
   int          sent_count = 0;
   int          quiet_cycles = 0;
   bit          calm = 1'b0;
   bit          paused = 1'b0;

   spi_master_tx_rx_ring_buffers u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 17);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic req_type make_req(input action_type a, input logic [7:0] txb,
                                        input logic [7:0] rxb, input logic f);
      req_type r;
      r.action  = a;
      r.tx_byte = txb;
      r.rx_byte = rxb;
      r.fault   = f;
      return r;
   endfunction

   function automatic req_type rand_req(input action_type a);
      return make_req(a, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
   endfunction

   // Drop valid for any gap; then raise it once per step and hold it until taken.
   task automatic send_item(input req_type r);
      int gap;
      gap = 0;
      if (!calm) while ($urandom_range(99) < 17) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      book.note_request(r);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic run_directed();
      send_item(make_req(ACT_PEEK_RX, 8'h00, 8'h00, 1'b0));
      send_item(make_req(ACT_READ_RX, 8'hFF, 8'hFF, 1'b1));
      send_item(make_req(ACT_TX_START, 8'h00, 8'h00, 1'b0));
      send_item(make_req(ACT_XFER_DONE, 8'h00, 8'hA5, 1'b0));
      send_item(make_req(ACT_NOP, 8'hFF, 8'hFF, 1'b1));
      send_item(make_req(ACT_FAULT, 8'h00, 8'hFF, 1'b0));
      send_item(make_req(ACT_FAULT, 8'hFF, 8'h00, 1'b1));
      send_item(make_req(ACT_WRITE_TX, 8'h00, 8'h00, 1'b0));
      send_item(make_req(ACT_WRITE_TX, 8'hFF, 8'h00, 1'b0));
      send_item(make_req(ACT_WRITE_TX, 8'h5A, 8'h00, 1'b0));
      send_item(make_req(ACT_TX_START, 8'h00, 8'h00, 1'b0));
      send_item(make_req(ACT_XFER_DONE, 8'h00, 8'hFF, 1'b0));
      send_item(make_req(ACT_XFER_DONE, 8'h00, 8'h81, 1'b1));
      send_item(make_req(ACT_XFER_DONE, 8'h00, 8'h7E, 1'b0));
      send_item(make_req(ACT_PEEK_RX, 8'h00, 8'h00, 1'b0));
      send_item(make_req(ACT_READ_RX, 8'h00, 8'h00, 1'b0));
      send_item(make_req(ACT_READ_RX, 8'h00, 8'h00, 1'b0));
      send_item(make_req(ACT_WRITE_TX, 8'h3C, 8'h00, 1'b0));
      send_item(make_req(ACT_CLEAR, 8'h00, 8'h00, 1'b0));
      send_item(make_req(ACT_READ_RX, 8'h00, 8'h00, 1'b0));
      // clear in the middle of a burst keeps it active
      send_item(make_req(ACT_WRITE_TX, 8'hC3, 8'h00, 1'b0));
      send_item(make_req(ACT_TX_START, 8'h00, 8'h00, 1'b0));
      send_item(make_req(ACT_CLEAR, 8'hFF, 8'hFF, 1'b1));
      send_item(make_req(ACT_PEEK_RX, 8'h00, 8'h00, 1'b0));
      send_item(make_req(ACT_XFER_DONE, 8'h00, 8'h11, 1'b0));
   endtask

   function automatic action_type noise_action();
      action_type a;
      a = action_type'($urandom_range(7));
      // keep clears rare so the rings can fill up
      if (a == ACT_CLEAR && $urandom_range(4) != 0) a = ACT_PEEK_RX;
      return a;
   endfunction

   task automatic run_burst();
      int n;
      int k;
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      repeat (n) send_item(rand_req(ACT_WRITE_TX));
      send_item(rand_req(ACT_TX_START));
      for (k = 0; k < n; k++) begin
         if ($urandom_range(9) == 0) send_item(rand_req(noise_action()));
         send_item(rand_req(ACT_XFER_DONE));
      end
      repeat ($urandom_range(0, n + 2))
         send_item(rand_req($urandom_range(1) ? ACT_READ_RX : ACT_PEEK_RX));
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 10)) send_item(rand_req(noise_action()));
   endtask

   task automatic run_flood();
      repeat ($urandom_range(60, 70))
         send_item(rand_req($urandom_range(1) ? ACT_FAULT : ACT_XFER_DONE));
   endtask

   task automatic run_reads();
      repeat ($urandom_range(1, 12))
         send_item(rand_req($urandom_range(3) != 0 ? ACT_READ_RX : ACT_PEEK_RX));
   endtask

   initial begin
      int pick;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      drain_results();
      while (sent_count < ITEM_TARGET) begin
         calm = (sent_count >= 800 && sent_count < 1100);
         if (!paused && sent_count >= 1000) begin
            drain_results();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 50) run_burst();
         else if (pick < 72) run_noise();
         else if (pick < 82) run_flood();
         else if (pick < 97) run_reads();
         else drain_results();
      end
      calm = 1'b0;
      drain_results();
      repeat (8) @(negedge clock);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
